// ----- src/trie_word_insert_lookup_core_assert.svh -----
// Assertion macros used by the checker of the trie word store.
`ifndef TRIE_WORD_INSERT_LOOKUP_CORE_ASSERT_SVH
`define TRIE_WORD_INSERT_LOOKUP_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TWIL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TWIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/twil_pkg.sv -----
// Types and constants of the trie word store.
package twil_pkg;

  localparam int LETTER_W = 5;

  typedef struct packed {
    logic                kind;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;
  } in_item_t;

  typedef struct packed {
    logic word_found;
    logic prefix_found;
    logic table_overflow;
  } out_item_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_MREAD,
    ST_MARK,
    ST_DONE
  } twil_state_e;

endpackage

// ----- src/twil_chan_if.sv -----
// Valid/ready channel interface carrying one payload item per transaction.
interface twil_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/trie_word_insert_lookup_core.sv -----
// Top level of the trie word store with insert and prefix lookup.
//
//   Port    Direction  Transaction
//   in_i    sink       one letter: kind, letter, last_letter
//   out_o   source     one result per word: word_found, prefix_found, table_overflow
//
// A non-final letter is taken in ST_IDLE alone at word start or on a lost path, else it
// also passes ST_WALK for one read of the current node's row. A final letter that walks
// passes ST_WALK, ST_MREAD to reread the reached row for the word-end mark, and ST_MARK;
// others skip some. After reset the node table is cleared one row a cycle, all NODE_COUNT rows,
// with in_i.ready low. A stalled result holds in the output register while the next word's letters are
// taken, and that word's final letter waits until the register frees.
module trie_word_insert_lookup_core #(
  parameter int NODE_COUNT    = 4096,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  twil_chan_if.sink   in_i,
  twil_chan_if.source out_o
);
  import twil_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int ROW_W  = ALPHABET_SIZE * NODE_W + 1;

  mem_cmd_t          mem_cmd;
  logic [NODE_W-1:0] mem_addr;
  logic [ROW_W-1:0]  mem_wdata;
  logic [ROW_W-1:0]  mem_rdata;

  twil_ctrl #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .NODE_W        (NODE_W),
    .ROW_W         (ROW_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_cmd_o   (mem_cmd),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  twil_node_mem #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (NODE_W),
    .ROW_W  (ROW_W)
  ) u_node_mem (
    .clk_i       (clk_i),
    .mem_cmd_i   (mem_cmd),
    .mem_addr_i  (mem_addr),
    .mem_wdata_i (mem_wdata),
    .mem_rdata_o (mem_rdata)
  );

endmodule

// ----- src/twil_node_mem.sv -----
// Single-port node table: one row per node holding its word-end mark and child links.
module twil_node_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int ROW_W  = 313
) (
  input  logic                clk_i,
  input  twil_pkg::mem_cmd_t  mem_cmd_i,
  input  logic [ADDR_W-1:0]   mem_addr_i,
  input  logic [ROW_W-1:0]    mem_wdata_i,
  output logic [ROW_W-1:0]    mem_rdata_o
);
  import twil_pkg::*;

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_cmd_i.wr) begin
      mem_q[mem_addr_i] <= mem_wdata_i;
    end
    if (mem_cmd_i.rd) begin
      rdata_q <= mem_q[mem_addr_i];
    end
  end

  assign mem_rdata_o = rdata_q;

endmodule

// ----- src/twil_ctrl.sv -----
// Letter sequencer: walks, allocates and marks trie nodes through the node table.
module twil_ctrl #(
  parameter int NODE_COUNT    = 4096,
  parameter int ALPHABET_SIZE = 26,
  parameter int NODE_W        = 12,
  parameter int ROW_W         = 313
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  twil_chan_if.sink           in_i,
  twil_chan_if.source         out_o,
  output twil_pkg::mem_cmd_t  mem_cmd_o,
  output logic [NODE_W-1:0]   mem_addr_o,
  output logic [ROW_W-1:0]    mem_wdata_o,
  input  logic [ROW_W-1:0]    mem_rdata_i
);
  import twil_pkg::*;

  localparam int LET_W    = $clog2(ALPHABET_SIZE);
  localparam int NMAX     = (NODE_COUNT > ALPHABET_SIZE) ? NODE_COUNT : ALPHABET_SIZE;
  localparam int NF_W     = $clog2(NMAX + 1);
  localparam int MARK_BIT = ROW_W - 1;

  twil_state_e state_q, state_d;

  logic [NODE_W-1:0]   cur_q, cur_d;
  logic [NODE_W-1:0]   clr_q, clr_d;
  logic [NF_W-1:0]     nf_q, nf_d;
  logic                lost_q, lost_d;
  logic                start_q, start_d;
  logic                fail_q, fail_d;
  logic                kind_q, kind_d;
  logic                last_q, last_d;
  logic                mark_q, mark_d;
  logic [LETTER_W-1:0] ch_q, ch_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  logic                accept;
  logic                out_free;
  logic                letter_bad;
  logic                walk_go;
  logic                lost_go;
  logic                child_none;
  logic                nf_full;
  logic                walk_miss;
  logic [LET_W-1:0]    ch_idx;
  logic [NODE_W-1:0]   child;
  logic [NODE_W-1:0]   start_node;
  logic [ROW_W-1:0]    link_row;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign letter_bad = (int'(in_i.data.letter) >= ALPHABET_SIZE);
  assign walk_go    = !start_q && !lost_q && !letter_bad;
  assign lost_go    = start_q ? letter_bad : (lost_q || letter_bad);
  assign start_node = NODE_W'(in_i.data.letter);

  assign ch_idx     = LET_W'(ch_q);
  assign child      = mem_rdata_i[ch_idx*NODE_W +: NODE_W];
  assign child_none = (child == '0);
  assign nf_full    = (nf_q >= NF_W'(NODE_COUNT));
  assign walk_miss  = child_none && (kind_q || nf_full);

  always_comb begin
    link_row = mem_rdata_i;
    link_row[ch_idx*NODE_W +: NODE_W] = nf_q[NODE_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (walk_go) begin
            state_d = ST_WALK;
          end else if (in_i.data.last_letter && !lost_go) begin
            state_d = ST_MARK;
          end else if (in_i.data.last_letter) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (last_q && !walk_miss) begin
          state_d = ST_MREAD;
        end else if (last_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MREAD: state_d = ST_MARK;
      ST_MARK:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    clr_d       = clr_q;
    nf_d        = nf_q;
    lost_d      = lost_q;
    start_d     = start_q;
    fail_d      = fail_q;
    kind_d      = kind_q;
    last_d      = last_q;
    mark_d      = mark_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    mem_cmd_o   = '0;
    mem_addr_o  = cur_q;
    mem_wdata_o = link_row;
    case (state_q)
      ST_CLEAR: begin
        mem_cmd_o.wr = 1'b1;
        mem_addr_o   = clr_q;
        mem_wdata_o  = '0;
        clr_d        = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          kind_d  = in_i.data.kind;
          ch_d    = in_i.data.letter;
          last_d  = in_i.data.last_letter;
          start_d = in_i.data.last_letter;
          lost_d  = lost_go;
          if (start_q) begin
            fail_d = 1'b0;
            cur_d  = start_node;
          end
          if (walk_go || (in_i.data.last_letter && !lost_go)) begin
            mem_cmd_o.rd = 1'b1;
            mem_addr_o   = start_q ? start_node : cur_q;
          end
        end
      end
      ST_WALK: begin
        if (walk_miss) begin
          lost_d = 1'b1;
          fail_d = fail_q || !kind_q;
        end else if (child_none) begin
          mem_cmd_o.wr = 1'b1;
          cur_d        = nf_q[NODE_W-1:0];
          nf_d         = nf_q + 1'b1;
        end else begin
          cur_d = child;
        end
      end
      ST_MREAD: begin
        mem_cmd_o.rd = 1'b1;
      end
      ST_MARK: begin
        mark_d = mem_rdata_i[MARK_BIT];
        mem_wdata_o = mem_rdata_i;
        mem_wdata_o[MARK_BIT] = 1'b1;
        if (!kind_q) begin
          mem_cmd_o.wr = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_data_d.word_found     = kind_q && !lost_q && mark_q;
          out_data_d.prefix_found   = kind_q && !lost_q;
          out_data_d.table_overflow = !kind_q && fail_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      nf_q        <= NF_W'(ALPHABET_SIZE);
      lost_q      <= 1'b0;
      start_q     <= 1'b1;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      nf_q        <= nf_d;
      lost_q      <= lost_d;
      start_q     <= start_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    last_q     <= last_d;
    mark_q     <= mark_d;
    ch_q       <= ch_d;
    out_data_q <= out_data_d;
  end

endmodule

// ----- src/twil_checker.sv -----
// Port-level checker for the trie word store and its bind to the top level.
`include "trie_word_insert_lookup_core_assert.svh"

module twil_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_word_i,
  input logic out_prefix_i,
  input logic out_ovf_i
);

  // A final letter always leaves the sequencer busy in the cycle after it is taken.
  `TWIL_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i, "input taken right after a final letter")

  // A new result is loaded only while no letter can be taken.
  `TWIL_ASSERT_SAME(a_result_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i), "result appeared while input was open")

  // A found word implies its prefix, and an overflow excludes a query hit.
  `TWIL_ASSERT_SAME(a_result_flags, clk_i, rst_ni, out_valid_i, (!out_word_i || out_prefix_i) && !(out_ovf_i && out_prefix_i), "inconsistent result flags")

  // A stalled result holds its value.
  `TWIL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word_i) && $stable(out_prefix_i) && $stable(out_ovf_i), "stalled result changed")

endmodule

bind trie_word_insert_lookup_core twil_checker u_twil_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.data.last_letter),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_word_i   (out_o.data.word_found),
  .out_prefix_i (out_o.data.prefix_found),
  .out_ovf_i    (out_o.data.table_overflow)
);
